[rtl/phdb_pkg.sv]
package phdb_pkg;

  // operation codes of an input item
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SAMPLE     = 3'd1;
  localparam logic [2:0] OP_MAN_ACID   = 3'd2;
  localparam logic [2:0] OP_MAN_BASE   = 3'd3;
  localparam logic [2:0] OP_CLR_ACID   = 3'd4;
  localparam logic [2:0] OP_CLR_BASE   = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_ENABLES   = 3'd0;
  localparam logic [2:0] REG_SETPOINT  = 3'd1;
  localparam logic [2:0] REG_DEADBAND  = 3'd2;
  localparam logic [2:0] REG_ACID_DOSE = 3'd3;
  localparam logic [2:0] REG_BASE_DOSE = 3'd4;
  localparam logic [2:0] REG_ACID_GAP  = 3'd5;
  localparam logic [2:0] REG_BASE_GAP  = 3'd6;
  localparam logic [2:0] REG_VOLUMES   = 3'd7;

  // pump codes
  localparam logic [1:0] PUMP_OFF      = 2'd0;
  localparam logic [1:0] PUMP_ACID     = 2'd1;
  localparam logic [1:0] PUMP_BASE     = 2'd2;

  // enable bits
  localparam int EN_AUTO = 0;
  localparam int EN_ACID = 1;
  localparam int EN_BASE = 2;

  // configuration reset values
  localparam logic [13:0] SETPOINT_RST = 14'd7000;
  localparam logic [13:0] DEADBAND_RST = 14'd100;
  localparam logic [15:0] DOSE_MS_RST  = 16'd1000;

  typedef struct packed {
    logic [2:0]  enables;
    logic [13:0] setpoint_mph;
    logic [13:0] deadband_mph;
    logic [15:0] acid_dose_ms;
    logic [15:0] base_dose_ms;
    logic [31:0] acid_gap_ms;
    logic [31:0] base_gap_ms;
    logic [31:0] dose_volumes;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        dosing_active;
    logic        dosing_is_acid;
    logic [31:0] dose_start_ms;
    logic [31:0] last_acid_ms;
    logic [31:0] last_base_ms;
    logic [31:0] acid_sum;
    logic [31:0] base_sum;
    logic        fault_flag;
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [13:0] ph_mph;
    logic        ph_valid;
  } item_t;

  typedef struct packed {
    logic [1:0]  pump;
    logic        fault;
    logic        accepted;
    logic        dose_started;
    logic        dose_finished;
    logic [31:0] acid_total;
    logic [31:0] base_total;
  } result_t;

endpackage

[rtl/ph_deadband_dosing_controller.sv]
// Two-sided pH dosing controller with a deadband.
// Input channel (in_valid/in_ready, fields op, ph_mph, ph_valid) carries ticks,
// pH samples, manual dose commands and total clears. Every input transfer
// produces exactly one result on the output channel (out_valid/out_ready):
// pump state, fault flag, accepted, dose_started, dose_finished and both
// saturating volume totals, all as they stand after the item.
// An item taken in sits in the input register, is worked out in a single
// combinational step and is loaded into the result register, which sets
// out_valid; a stall on the output can keep it waiting in the input register.
// Throughput: one item per cycle while the receiver takes every result, as
// the step between the input and result registers is combinational.
// A stalled receiver holds the result register; the input register then
// keeps its item and in_ready drops once both registers are full.
// cfg_wen writes register cfg_index from cfg_wdata at once; write only while
// no item is in flight.
// Reset (rst, synchronous) clears the clock, totals, dose and fault state,
// empties both registers and loads the register defaults.
module ph_deadband_dosing_controller import phdb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [13:0] ph_mph,
  input  logic        ph_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  pump,
  output logic        fault,
  output logic        accepted,
  output logic        dose_started,
  output logic        dose_finished,
  output logic [31:0] acid_total,
  output logic [31:0] base_total,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item;
  logic    item_valid;
  result_t res_next;
  result_t res;
  logic    advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enables      <= '0;
      cfg.setpoint_mph <= SETPOINT_RST;
      cfg.deadband_mph <= DEADBAND_RST;
      cfg.acid_dose_ms <= DOSE_MS_RST;
      cfg.base_dose_ms <= DOSE_MS_RST;
      cfg.acid_gap_ms  <= '0;
      cfg.base_gap_ms  <= '0;
      cfg.dose_volumes <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_ENABLES:   cfg.enables      <= cfg_wdata[2:0];
        REG_SETPOINT:  cfg.setpoint_mph <= cfg_wdata[13:0];
        REG_DEADBAND:  cfg.deadband_mph <= cfg_wdata[13:0];
        REG_ACID_DOSE: cfg.acid_dose_ms <= cfg_wdata[15:0];
        REG_BASE_DOSE: cfg.base_dose_ms <= cfg_wdata[15:0];
        REG_ACID_GAP:  cfg.acid_gap_ms  <= cfg_wdata;
        REG_BASE_GAP:  cfg.base_gap_ms  <= cfg_wdata;
        REG_VOLUMES:   cfg.dose_volumes <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.op       <= op;
      item.ph_mph   <= ph_mph;
      item.ph_valid <= ph_valid;
    end
  end

  phdb_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // result register: load on advance, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign pump          = res.pump;
  assign fault         = res.fault;
  assign accepted      = res.accepted;
  assign dose_started  = res.dose_started;
  assign dose_finished = res.dose_finished;
  assign acid_total    = res.acid_total;
  assign base_total    = res.base_total;

  a_start_pumps: assert property (@(posedge clk) disable iff (rst)
    out_valid && dose_started |-> pump != PUMP_OFF)
    else $error("dose started but pump off");

  a_refused_no_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> !dose_started)
    else $error("refused command started a dose");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without an item");

endmodule

[rtl/phdb_step.sv]
module phdb_step import phdb_pkg::*; (
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic [32:0] acid_add;
  logic [32:0] base_add;
  logic [31:0] acid_sat;
  logic [31:0] base_sat;
  logic        acid_gap_ok;
  logic        base_gap_ok;
  logic        acid_rdy;
  logic        base_rdy;
  logic [15:0] dur;
  logic        timed_out;
  logic [14:0] band_hi;
  logic [14:0] ph_plus_db;
  logic        ph_high;
  logic        ph_low;
  logic        active_after;
  logic        do_start;
  logic        start_acid;
  logic        accepted;
  logic        finished;

  assign acid_add = {1'b0, cur.acid_sum} + {17'd0, cfg.dose_volumes[15:0]};
  assign base_add = {1'b0, cur.base_sum} + {17'd0, cfg.dose_volumes[31:16]};
  assign acid_sat = acid_add[32] ? '1 : acid_add[31:0];
  assign base_sat = base_add[32] ? '1 : base_add[31:0];

  // a zero gap always passes; elapsed time is a wrapping difference
  assign acid_gap_ok = (cfg.acid_gap_ms == '0) ||
                       ((cur.now_ms - cur.last_acid_ms) >= cfg.acid_gap_ms);
  assign base_gap_ok = (cfg.base_gap_ms == '0) ||
                       ((cur.now_ms - cur.last_base_ms) >= cfg.base_gap_ms);
  assign acid_rdy = cfg.enables[EN_ACID] && acid_gap_ok;
  assign base_rdy = cfg.enables[EN_BASE] && base_gap_ok;

  assign dur       = cur.dosing_is_acid ? cfg.acid_dose_ms : cfg.base_dose_ms;
  assign timed_out = (cur.now_ms - cur.dose_start_ms) >= {16'd0, dur};

  // lower limit as ph + deadband < setpoint, so it never goes negative
  assign band_hi    = {1'b0, cfg.setpoint_mph} + {1'b0, cfg.deadband_mph};
  assign ph_plus_db = {1'b0, item.ph_mph} + {1'b0, cfg.deadband_mph};
  assign ph_high    = {1'b0, item.ph_mph} > band_hi;
  assign ph_low     = ph_plus_db < {1'b0, cfg.setpoint_mph};

  always_comb begin
    nxt          = cur;
    accepted     = 1'b1;
    finished     = 1'b0;
    do_start     = 1'b0;
    start_acid   = 1'b0;
    active_after = cur.dosing_active;
    unique case (item.op)
      OP_TICK: begin
        nxt.now_ms = cur.now_ms + 32'd1;
      end
      OP_SAMPLE: begin
        nxt.fault_flag = !item.ph_valid;
        if (item.ph_valid) begin
          if (cur.dosing_active && timed_out) begin
            active_after = 1'b0;
            finished     = 1'b1;
          end
          if (cfg.enables[EN_AUTO] && !active_after) begin
            if (ph_high) begin
              do_start   = acid_rdy;
              start_acid = 1'b1;
            end else if (ph_low) begin
              do_start   = base_rdy;
            end
          end
        end
      end
      OP_MAN_ACID: begin
        start_acid = 1'b1;
        do_start   = !cur.dosing_active && acid_rdy;
        accepted   = do_start;
      end
      OP_MAN_BASE: begin
        do_start   = !cur.dosing_active && base_rdy;
        accepted   = do_start;
      end
      OP_CLR_ACID: begin
        nxt.acid_sum = '0;
      end
      OP_CLR_BASE: begin
        nxt.base_sum = '0;
      end
      default: begin
      end
    endcase

    nxt.dosing_active = active_after;
    if (do_start) begin
      nxt.dosing_active  = 1'b1;
      nxt.dosing_is_acid = start_acid;
      nxt.dose_start_ms  = cur.now_ms;
      if (start_acid) begin
        nxt.last_acid_ms = cur.now_ms;
        nxt.acid_sum     = acid_sat;
      end else begin
        nxt.last_base_ms = cur.now_ms;
        nxt.base_sum     = base_sat;
      end
    end

    res.pump          = !nxt.dosing_active ? PUMP_OFF :
                        (nxt.dosing_is_acid ? PUMP_ACID : PUMP_BASE);
    res.fault         = nxt.fault_flag;
    res.accepted      = accepted;
    res.dose_started  = do_start;
    res.dose_finished = finished;
    res.acid_total    = nxt.acid_sum;
    res.base_total    = nxt.base_sum;
  end

endmodule
